>>> rtl/rte_pkg.sv
// Package for the postfix trigger logic evaluator.
// Holds the command encoding, register indexes and the per-stage evaluation state type.
// No dependencies.
package rte_pkg;

  localparam int STACK_DEPTH   = 32;
  localparam int DEPTH_W       = 6;
  localparam int SIG_W         = 32;
  localparam int CMD_W         = 8;
  localparam int PROG_WORDS    = 4;
  localparam int CMDS_PER_WORD = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int LEN_W         = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_PROG_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_LENGTH = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_AND  = 3'd1,
    OP_OR   = 3'd2,
    OP_NOT  = 3'd3,
    OP_SWAP = 3'd4,
    OP_DROP = 3'd5
  } opcode_t;

  typedef struct packed {
    logic [STACK_DEPTH-1:0] stk;
    logic [DEPTH_W-1:0]     depth;
    logic                   under;
  } eval_t;

endpackage

>>> rtl/rte_cfg.sv
// Configuration registers of the trigger logic evaluator.
// Stores the packed program and its length and unpacks one command per stage.
// Depends on rte_pkg.
module rte_cfg import rte_pkg::*; #(
  parameter int MAX_COMMANDS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [CFG_DATA_W-1:0]                cfg_data,
  output logic [MAX_COMMANDS-1:0][CMD_W-1:0]   cmd_o,
  output logic [MAX_COMMANDS-1:0]              cmd_en_o,
  output logic [LEN_W-1:0]                     len_o
);

  logic [PROG_WORDS-1:0][CFG_DATA_W-1:0] prog_word_r;
  logic [LEN_W-1:0]                      prog_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_word_r <= '0;
      prog_len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROG_WORD_0: prog_word_r[0] <= cfg_data;
        CFG_PROG_WORD_1: prog_word_r[1] <= cfg_data;
        CFG_PROG_WORD_2: prog_word_r[2] <= cfg_data;
        CFG_PROG_WORD_3: prog_word_r[3] <= cfg_data;
        CFG_PROG_LENGTH: prog_len_r     <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths above the stage count saturate.
  assign len_o = (prog_len_r > LEN_W'(MAX_COMMANDS)) ? LEN_W'(MAX_COMMANDS) : prog_len_r;

  for (genvar k = 0; k < MAX_COMMANDS; k++) begin : g_cmd
    assign cmd_o[k]    = prog_word_r[k / CMDS_PER_WORD][CMD_W*(k % CMDS_PER_WORD) +: CMD_W];
    assign cmd_en_o[k] = (LEN_W'(k) < len_o);
  end

endmodule

>>> rtl/rte_stage.sv
// One pipeline stage of the trigger logic evaluator.
// Applies a single command to the one-bit stack and registers the item.
// Depends on rte_pkg.
module rte_stage import rte_pkg::*; #(
  parameter int NUM_SIGNALS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  input  logic [NUM_SIGNALS-1:0] sig_i,
  input  eval_t                  st_i,
  input  logic [CMD_W-1:0]       cmd_i,
  input  logic                   cmd_en_i,
  output logic                   valid_o,
  output logic [NUM_SIGNALS-1:0] sig_o,
  output eval_t                  st_o
);

  logic                   valid_r;
  logic [NUM_SIGNALS-1:0] sig_r;
  eval_t                  st_r;
  eval_t                  st_nxt;
  logic [SIG_W-1:0]       sig_ext;
  logic [4:0]             top_idx;
  logic [4:0]             sec_idx;
  logic                   a_bit;
  logic                   b_bit;
  logic                   push_bit;
  logic                   two_ok;
  logic                   one_ok;

  assign sig_ext  = SIG_W'(sig_i);
  assign push_bit = sig_ext[cmd_i[4:0]];
  assign top_idx  = 5'(st_i.depth - DEPTH_W'(1));
  assign sec_idx  = 5'(st_i.depth - DEPTH_W'(2));
  assign a_bit    = st_i.stk[top_idx];
  assign b_bit    = st_i.stk[sec_idx];
  assign two_ok   = (st_i.depth >= DEPTH_W'(2));
  assign one_ok   = (st_i.depth != '0);

  always_comb begin
    st_nxt = st_i;
    if (cmd_en_i) begin
      unique case (opcode_t'(cmd_i[7:5]))
        OP_PUSH: begin
          if (st_i.depth < DEPTH_W'(STACK_DEPTH)) begin
            st_nxt.stk[st_i.depth[4:0]] = push_bit;
            st_nxt.depth = st_i.depth + DEPTH_W'(1);
          end
        end
        OP_AND, OP_OR: begin
          if (two_ok) begin
            st_nxt.stk[sec_idx] = (cmd_i[7:5] == OP_AND) ? (a_bit & b_bit) : (a_bit | b_bit);
            st_nxt.stk[top_idx] = 1'b0;
            st_nxt.depth = st_i.depth - DEPTH_W'(1);
          end
        end
        OP_SWAP: begin
          if (two_ok) begin
            st_nxt.stk[sec_idx] = a_bit;
            st_nxt.stk[top_idx] = b_bit;
          end
        end
        OP_NOT: begin
          if (one_ok) st_nxt.stk[top_idx] = ~a_bit;
          else st_nxt.under = 1'b1;
        end
        OP_DROP: begin
          if (one_ok) begin
            st_nxt.stk[top_idx] = 1'b0;
            st_nxt.depth = st_i.depth - DEPTH_W'(1);
          end else begin
            st_nxt.under = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_i;
  end

  always_ff @(posedge clk) begin
    sig_r <= sig_i;
    st_r  <= st_nxt;
  end

  assign valid_o = valid_r;
  assign sig_o   = sig_r;
  assign st_o    = st_r;

endmodule

>>> rtl/rpn_trigger_logic_evaluator.sv
// Top level of the postfix trigger logic evaluator: config registers, command pipeline, output.
// The pipeline has one stage per command plus the output register.
// Throughput is one item per cycle; busy stays low and the receiver cannot stall.
// Synchronous active-low reset clears the program, the program length and all valid bits.
// Depends on rte_pkg, rte_cfg and rte_stage.
module rpn_trigger_logic_evaluator import rte_pkg::*; #(
  parameter int NUM_SIGNALS  = 32,
  parameter int MAX_COMMANDS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [SIG_W-1:0]      in_signals,
  output logic                  out_valid,
  output logic                  out_result,
  output logic                  out_empty_result,
  output logic                  out_underflow,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [MAX_COMMANDS-1:0][CMD_W-1:0] cmd;
  logic [MAX_COMMANDS-1:0]            cmd_en;
  logic [LEN_W-1:0]                   len_eff;
  logic [MAX_COMMANDS:0]              vld;
  logic [NUM_SIGNALS-1:0]             sig [MAX_COMMANDS+1];
  eval_t                              st  [MAX_COMMANDS+1];
  eval_t                              fin;
  logic                               out_valid_r;
  logic                               out_result_r;
  logic                               out_empty_r;
  logic                               out_under_r;

  assign busy = 1'b0;

  rte_cfg #(.MAX_COMMANDS(MAX_COMMANDS)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_o    (cmd),
    .cmd_en_o (cmd_en),
    .len_o    (len_eff)
  );

  assign vld[0] = start && !busy;
  assign sig[0] = in_signals[NUM_SIGNALS-1:0];
  assign st[0]  = '0;

  for (genvar k = 0; k < MAX_COMMANDS; k++) begin : g_stage
    rte_stage #(.NUM_SIGNALS(NUM_SIGNALS)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (vld[k]),
      .sig_i   (sig[k]),
      .st_i    (st[k]),
      .cmd_i   (cmd[k]),
      .cmd_en_i(cmd_en[k]),
      .valid_o (vld[k+1]),
      .sig_o   (sig[k+1]),
      .st_o    (st[k+1])
    );
  end

  assign fin = st[MAX_COMMANDS];

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= vld[MAX_COMMANDS];
  end

  always_ff @(posedge clk) begin
    out_empty_r  <= (fin.depth == '0);
    out_result_r <= (fin.depth != '0) ? fin.stk[5'(fin.depth - DEPTH_W'(1))] : 1'b0;
    out_under_r  <= fin.under;
  end

  assign out_valid        = out_valid_r;
  assign out_result       = out_result_r;
  assign out_empty_result = out_empty_r;
  assign out_underflow    = out_under_r;

  a_empty_forces_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_empty_result && out_result))
    else $error("Empty stack gave a nonzero result.");

  a_empty_program: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && len_eff == '0) |-> (out_empty_result && !out_underflow))
    else $error("Empty program gave a nonempty or flagged result.");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld[MAX_COMMANDS] |-> (fin.depth <= len_eff))
    else $error("Stack depth exceeds the number of executed commands.");

endmodule

>>> tb/tb_rpn_trigger_logic_evaluator.sv
// Self-checking testbench for the postfix trigger logic evaluator.
// Each trigger word is evaluated by a local predictor, and every result strobe is checked
// against it in order. Depends on rte_pkg and rpn_trigger_logic_evaluator.
module tb_rpn_trigger_logic_evaluator;
  import rte_pkg::*;

  localparam int NUM_CMDS     = PROG_WORDS * CMDS_PER_WORD;
  localparam int RANDOM_WORDS = 600;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  typedef struct packed {
    logic result;
    logic empty_result;
    logic underflow;
  } verdict_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [SIG_W-1:0]      in_signals;
  logic                  out_valid;
  logic                  out_result;
  logic                  out_empty_result;
  logic                  out_underflow;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [CFG_DATA_W-1:0] prog_word_reg [PROG_WORDS];
  logic [LEN_W-1:0]      prog_length_reg;
  logic [CMD_W*NUM_CMDS-1:0] program_image;
  int                    image_len;
  verdict_t              pending_verdicts[$];
  verdict_t              oldest;
  int                    fail_count;
  int                    word_mode;

  rpn_trigger_logic_evaluator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_signals       (in_signals),
    .out_valid        (out_valid),
    .out_result       (out_result),
    .out_empty_result (out_empty_result),
    .out_underflow    (out_underflow),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic verdict_t evaluate_formula(input logic [SIG_W-1:0] sig);
    logic [STACK_DEPTH-1:0] stk;
    int depth;
    int len;
    int k;
    logic [CMD_W-1:0] cmd;
    logic [2:0] op;
    logic top;
    verdict_t v;
    stk = '0;
    depth = 0;
    v = '0;
    len = (prog_length_reg > NUM_CMDS) ? NUM_CMDS : int'(prog_length_reg);
    for (k = 0; k < len; k++) begin
      cmd = prog_word_reg[k / CMDS_PER_WORD][CMD_W * (k % CMDS_PER_WORD) +: CMD_W];
      op = cmd[7:5];
      case (op)
        OP_PUSH: begin
          if (depth < STACK_DEPTH) begin
            stk[depth] = sig[cmd[4:0]];
            depth++;
          end
        end
        OP_AND, OP_OR: begin
          if (depth >= 2) begin
            top = stk[depth-1];
            stk[depth-2] = (op == OP_AND) ? (top & stk[depth-2]) : (top | stk[depth-2]);
            depth--;
          end
        end
        OP_NOT: begin
          if (depth > 0) stk[depth-1] = ~stk[depth-1];
          else v.underflow = 1'b1;
        end
        OP_SWAP: begin
          if (depth >= 2) begin
            top = stk[depth-1];
            stk[depth-1] = stk[depth-2];
            stk[depth-2] = top;
          end
        end
        OP_DROP: begin
          if (depth > 0) depth--;
          else v.underflow = 1'b1;
        end
        default: ;
      endcase
    end
    if (depth > 0) v.result = stk[depth-1];
    else v.empty_result = 1'b1;
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $error("result strobe with no item outstanding");
        fail_count++;
      end else begin
        oldest = pending_verdicts.pop_front();
        if (out_result !== oldest.result) begin
          $error("result: expected %0b, actual %0b", oldest.result, out_result);
          fail_count++;
        end
        if (out_empty_result !== oldest.empty_result) begin
          $error("empty_result: expected %0b, actual %0b", oldest.empty_result,
                 out_empty_result);
          fail_count++;
        end
        if (out_underflow !== oldest.underflow) begin
          $error("underflow: expected %0b, actual %0b", oldest.underflow, out_underflow);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit last);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx <= CFG_PROG_WORD_3) prog_word_reg[idx[1:0]] = data;
    else if (idx == CFG_PROG_LENGTH) prog_length_reg = data[LEN_W-1:0];
    if (last) cfg_we <= 1'b0;
  endtask

  task automatic load_program(input logic [CFG_DATA_W-1:0] len_data);
    int w;
    for (w = 0; w < PROG_WORDS; w++)
      write_reg(CFG_PROG_WORD_0 + CFG_IDX_W'(w), program_image[CFG_DATA_W*w +: CFG_DATA_W],
                1'b0);
    write_reg(CFG_PROG_LENGTH, len_data, 1'b1);
  endtask

  function automatic void clear_image();
    int i;
    for (i = 0; i < NUM_CMDS / 4; i++) program_image[32*i +: 32] = $urandom;
    image_len = 0;
  endfunction

  function automatic void add_cmd(input logic [2:0] op, input logic [4:0] idx);
    program_image[CMD_W*image_len +: CMD_W] = {op, idx};
    image_len++;
  endfunction

  function automatic logic [SIG_W-1:0] random_word();
    case (word_mode)
      1: return $urandom & $urandom & $urandom;
      2: return $urandom | $urandom | $urandom;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [SIG_W-1:0] word);
    start      <= 1'b1;
    in_signals <= word;
    do @(posedge clk); while (busy !== 1'b0);
    pending_verdicts = {pending_verdicts, evaluate_formula(word)};
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  task automatic send_batch(input int count, input bit steady);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && count > 0) begin
        send_word(random_word());
        burst--;
        count--;
      end
      if (count > 0 && $urandom_range(0, 19) == 0) begin
        wait_drained();
      end else if (!steady && count > 0 && $urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic test_reset_program();
    send_word('0);
    send_word('1);
    wait_drained();
  endtask

  task automatic test_each_operation();
    clear_image();
    add_cmd(OP_PUSH, 5'd0);
    add_cmd(OP_PUSH, 5'd31);
    add_cmd(OP_AND, 5'd0);
    add_cmd(OP_PUSH, 5'd7);
    add_cmd(OP_OR, 5'd0);
    add_cmd(OP_NOT, 5'd0);
    add_cmd(OP_PUSH, 5'd1);
    add_cmd(OP_PUSH, 5'd2);
    add_cmd(OP_SWAP, 5'd0);
    add_cmd(OP_DROP, 5'd0);
    add_cmd(OP_RSVD_6, 5'd17);
    add_cmd(OP_AND, 5'd0);
    add_cmd(OP_RSVD_7, 5'd31);
    add_cmd(OP_PUSH, 5'd3);
    add_cmd(OP_PUSH, 5'd4);
    add_cmd(OP_OR, 5'd0);
    add_cmd(OP_SWAP, 5'd0);
    load_program(CFG_DATA_W'(image_len));
    send_word('0);
    send_word('1);
    send_word(32'h8000_0001);
    send_word(32'h0000_008A);
    send_word($urandom);
    send_word($urandom);
    wait_drained();
  endtask

  task automatic test_stack_underflow();
    clear_image();
    add_cmd(OP_NOT, 5'd0);
    add_cmd(OP_DROP, 5'd0);
    add_cmd(OP_AND, 5'd0);
    add_cmd(OP_OR, 5'd0);
    add_cmd(OP_SWAP, 5'd0);
    add_cmd(OP_PUSH, 5'd9);
    add_cmd(OP_AND, 5'd0);
    add_cmd(OP_SWAP, 5'd0);
    add_cmd(OP_NOT, 5'd0);
    load_program(CFG_DATA_W'(image_len));
    send_word(32'h0000_0200);
    send_word(32'hFFFF_FDFF);
    wait_drained();
    clear_image();
    add_cmd(OP_PUSH, 5'd3);
    add_cmd(OP_DROP, 5'd0);
    load_program(CFG_DATA_W'(image_len));
    send_word('1);
    send_word('0);
    wait_drained();
  endtask

  task automatic test_length_extremes();
    int k;
    // A full stack of pushes, with an over-range length that must saturate.
    clear_image();
    for (k = 0; k < NUM_CMDS; k++) add_cmd(OP_PUSH, k[4:0]);
    load_program('1);
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    wait_drained();
    program_image = '1;
    load_program(CFG_DATA_W'(NUM_CMDS));
    send_word($urandom);
    wait_drained();
    program_image = '0;
    load_program(CFG_DATA_W'(NUM_CMDS));
    send_word(32'h0000_0001);
    send_word(32'hFFFF_FFFE);
    wait_drained();
    write_reg(CFG_PROG_LENGTH, '0, 1'b1);
    send_word('1);
    wait_drained();
  endtask

  task automatic test_unused_index();
    int i;
    clear_image();
    add_cmd(OP_PUSH, 5'd12);
    add_cmd(OP_NOT, 5'd0);
    for (i = CFG_PROG_LENGTH + 1; i < 2**CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), '1, 1'b0);
    load_program(CFG_DATA_W'(image_len));
    send_word(32'h0000_1000);
    send_word(32'hFFFF_EFFF);
    wait_drained();
  endtask

  task automatic test_random_formulas();
    int sent;
    int n;
    int depth;
    int batch;
    logic [2:0] op;
    logic [CFG_DATA_W-1:0] len_data;
    logic [CFG_DATA_W-1:0] noise;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      clear_image();
      n = $urandom_range(1, NUM_CMDS);
      if ($urandom_range(0, 9) == 0) begin
        image_len = n;
      end else begin
        depth = 0;
        while (image_len < n) begin
          if ($urandom_range(0, 9) == 0) op = 3'($urandom);
          else if (depth == 0 || (depth == 1 && $urandom_range(0, 2) != 0)) op = OP_PUSH;
          else begin
            case ($urandom_range(0, 7))
              0, 1:    op = OP_PUSH;
              2:       op = OP_AND;
              3:       op = OP_OR;
              4:       op = OP_NOT;
              5:       op = OP_SWAP;
              6:       op = OP_DROP;
              default: op = OP_AND;
            endcase
          end
          add_cmd(op, 5'($urandom));
          if (op == OP_PUSH && depth < STACK_DEPTH) depth++;
          else if ((op == OP_AND || op == OP_OR) && depth >= 2) depth--;
          else if (op == OP_DROP && depth > 0) depth--;
        end
      end
      len_data = CFG_DATA_W'(image_len);
      case ($urandom_range(0, 7))
        0: len_data = CFG_DATA_W'($urandom_range(0, 2**LEN_W - 1));
        1: begin
          noise = {$urandom, $urandom};
          len_data[CFG_DATA_W-1:LEN_W] = noise[CFG_DATA_W-1:LEN_W];
        end
        default: ;
      endcase
      load_program(len_data);
      word_mode = $urandom_range(0, 2);
      batch = $urandom_range(10, 30);
      send_batch(batch, $urandom_range(0, 4) == 0);
      sent += batch;
      wait_drained();
    end
  endtask

  initial begin
    int i;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_signals = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    fail_count = 0;
    word_mode  = 0;
    for (i = 0; i < PROG_WORDS; i++) prog_word_reg[i] = '0;
    prog_length_reg = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_program();
    test_each_operation();
    test_stack_underflow();
    test_length_extremes();
    test_unused_index();
    test_random_formulas();
    wait_drained();
    repeat (2 * NUM_CMDS) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
